// ----- hdl/tic_pkg.sv -----
// Shared types and helpers for the triangle iso-band polygon clip unit.
// Used by tic_front, tic_back and the top level; no dependencies.
package tic_pkg;

  localparam int LEV_W = 21;
  localparam int LAM_W = 17;
  localparam int SLOTS = 9;

  typedef logic signed [LEV_W-1:0] level_t;
  typedef logic signed [15:0] value_t;

  typedef enum logic [1:0] {
    REG_LEVEL_BASE = 2'd0,
    REG_LEVEL_STEP = 2'd1,
    REG_LEVEL_COUNT = 2'd2,
    REG_BAND_TOL = 2'd3
  } reg_index_t;

  typedef struct packed {
    logic [2:0] band;
    level_t lo;
    level_t hi;
    value_t f0;
    value_t f1;
    value_t f2;
    logic [SLOTS-1:0] mask;
    logic [3:0] count;
    logic last;
    logic emit;
  } band_t;

  function automatic logic [1:0] next_corner(input logic [1:0] e);
    next_corner = (e == 2'd2) ? 2'd0 : e + 2'd1;
  endfunction

  function automatic level_t ext_value(input value_t v);
    ext_value = {{(LEV_W-16){v[15]}}, v};
  endfunction

  // Level crossed in position sel (0 nearer the start corner) on edge fi->fj
  function automatic level_t cross_level(input value_t fi, input value_t fj,
                                         input level_t lo, input level_t hi,
                                         input logic sel);
    logic desc;
    desc = (fj < fi);
    cross_level = (desc ^ sel) ? hi : lo;
  endfunction

  function automatic logic crosses(input value_t fi, input value_t fj, input level_t lv);
    level_t a;
    level_t b;
    a = ext_value(fi);
    b = ext_value(fj);
    crosses = (fi != fj) && ((a <= lv && b >= lv) || (a >= lv && b <= lv));
  endfunction

endpackage

// ----- hdl/tic_front.sv -----
// Front part: accepts triangles and classifies each band, one band a cycle while the queue is not full.
// Pushes band descriptors into the queue; depends on tic_pkg.
module tic_front #(
  parameter int MAX_LEVELS = 8,
  parameter int COORD_BITS = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  logic [6*COORD_BITS-1:0] in_crd,
  input  tic_pkg::value_t in_f0,
  input  tic_pkg::value_t in_f1,
  input  tic_pkg::value_t in_f2,
  input  tic_pkg::value_t level_base,
  input  logic [15:0] level_step,
  input  logic [3:0] level_count,
  input  logic [7:0] band_tolerance,
  input  logic q_full,
  output logic push,
  output tic_pkg::band_t push_band,
  output logic [6*COORD_BITS-1:0] push_crd
);
  import tic_pkg::*;

  typedef enum logic {F_IDLE, F_RUN} fstate_t;

  fstate_t state;
  logic [6*COORD_BITS-1:0] crd;
  value_t f [3];
  level_t lo;
  level_t hi;
  logic [2:0] b;
  logic [2:0] nb;
  logic [3:0] cnt_eff;
  logic [SLOTS-1:0] mask;
  logic [3:0] count;
  logic last;
  level_t tol;

  assign in_stall = (state != F_IDLE);
  assign cnt_eff = (level_count > 4'(MAX_LEVELS)) ? 4'(MAX_LEVELS) : level_count;
  assign hi = lo + level_t'({5'b0, level_step});
  assign tol = level_t'({13'b0, band_tolerance});
  assign last = (b == nb - 3'd1);

  always_comb begin
    level_t fj;
    mask = '0;
    for (int e = 0; e < 3; e++) begin
      fj = ext_value(f[next_corner(2'(e))]);
      mask[3*e]   = crosses(f[e], f[next_corner(2'(e))],
                            cross_level(f[e], f[next_corner(2'(e))], lo, hi, 1'b0));
      mask[3*e+1] = crosses(f[e], f[next_corner(2'(e))],
                            cross_level(f[e], f[next_corner(2'(e))], lo, hi, 1'b1));
      mask[3*e+2] = (lo - tol <= fj) && (fj <= hi + tol);
    end
    count = '0;
    for (int s = 0; s < SLOTS; s++) begin
      count = count + 4'(mask[s]);
    end
  end

  assign push = (state == F_RUN) && !q_full;
  assign push_crd = crd;
  always_comb begin
    push_band.band = b;
    push_band.lo = lo;
    push_band.hi = hi;
    push_band.f0 = f[0];
    push_band.f1 = f[1];
    push_band.f2 = f[2];
    push_band.mask = mask;
    push_band.count = count;
    push_band.last = last;
    push_band.emit = (count > 4'd2);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      case (state)
        F_IDLE: begin
          if (in_valid) begin
            crd <= in_crd;
            f[0] <= in_f0;
            f[1] <= in_f1;
            f[2] <= in_f2;
            lo <= ext_value(level_base);
            b <= '0;
            nb <= 3'(cnt_eff - 4'd1);
            // fewer than two levels: no band, nothing to do
            if (cnt_eff >= 4'd2) state <= F_RUN;
          end
        end
        F_RUN: begin
          if (!q_full) begin
            lo <= hi;
            b <= b + 3'd1;
            if (last) state <= F_IDLE;
          end
        end
        default: state <= F_IDLE;
      endcase
    end
  end

endmodule

// ----- hdl/tic_fifo.sv -----
// Two-entry queue between the front and back parts.
// Generic payload width; no package dependency.
module tic_fifo #(
  parameter int WIDTH = 8
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  logic [WIDTH-1:0] wdata,
  input  logic pop,
  output logic [WIDTH-1:0] rdata,
  output logic full,
  output logic empty
);
  logic [WIDTH-1:0] mem [2];
  logic wr_ptr;
  logic rd_ptr;
  logic [1:0] fill;

  assign full = (fill == 2'd2);
  assign empty = (fill == 2'd0);
  assign rdata = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      fill <= fill + 2'(push) - 2'(pop);
    end
  end

endmodule

// ----- hdl/tic_back.sv -----
// Back part: walks band slots, divides and interpolates crossings, emits vertices.
// Holds one vertex back to mark the triangle's last result; depends on tic_pkg.
module tic_back #(
  parameter int COORD_BITS = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic q_empty,
  output logic pop,
  input  tic_pkg::band_t q_band,
  input  logic [6*COORD_BITS-1:0] q_crd,
  output logic out_valid,
  input  logic out_stall,
  output logic signed [COORD_BITS-1:0] vertex_x,
  output logic signed [COORD_BITS-1:0] vertex_y,
  output logic [2:0] band_index,
  output logic [3:0] vertex_index,
  output logic polygon_end,
  output logic triangle_end
);
  import tic_pkg::*;

  localparam int P_W = COORD_BITS + 1 + LAM_W + 1;

  typedef enum logic [2:0] {B_IDLE, B_SLOT, B_DIV, B_MUL, B_ADD, B_PUSH, B_END} bstate_t;

  bstate_t state;
  band_t ent;
  logic [6*COORD_BITS-1:0] crd;
  logic [1:0] e;
  logic [1:0] t;
  logic [1:0] j;
  logic [3:0] k;
  logic [LAM_W-1:0] rem;
  logic [LAM_W-1:0] den;
  logic [15:0] q;
  logic [3:0] dcnt;
  logic [LAM_W-1:0] lam;
  logic signed [P_W-1:0] prod_x;
  logic signed [P_W-1:0] prod_y;
  logic signed [COORD_BITS-1:0] cand_x;
  logic signed [COORD_BITS-1:0] cand_y;
  logic held_valid;
  logic signed [COORD_BITS-1:0] held_x;
  logic signed [COORD_BITS-1:0] held_y;
  logic [2:0] held_band;
  logic [3:0] held_idx;
  logic held_pend;

  value_t fv [3];
  logic signed [COORD_BITS-1:0] px [3];
  logic signed [COORD_BITS-1:0] py [3];
  value_t fi;
  value_t fj;
  level_t lv;
  level_t num;
  level_t dff;
  logic [LAM_W-1:0] an;
  logic [LAM_W-1:0] ad;
  logic [LAM_W:0] rem2;
  logic rem_ge;
  logic [3:0] slot;
  logic last_slot;
  logic out_free;
  logic out_load;
  logic signed [COORD_BITS:0] dx;
  logic signed [COORD_BITS:0] dy;
  logic signed [P_W-1:0] lam_s;
  logic signed [P_W-1:0] sum_x;
  logic signed [P_W-1:0] sum_y;

  always_comb begin
    fv[0] = ent.f0;
    fv[1] = ent.f1;
    fv[2] = ent.f2;
    for (int c = 0; c < 3; c++) begin
      px[c] = crd[2*c*COORD_BITS +: COORD_BITS];
      py[c] = crd[(2*c+1)*COORD_BITS +: COORD_BITS];
    end
  end

  assign j = next_corner(e);
  assign fi = fv[e];
  assign fj = fv[j];
  assign lv = cross_level(fi, fj, ent.lo, ent.hi, t[0]);
  assign num = ext_value(fi) - lv;
  assign dff = ext_value(fi) - ext_value(fj);
  assign an = num[LEV_W-1] ? LAM_W'(-num) : LAM_W'(num);
  assign ad = dff[LEV_W-1] ? LAM_W'(-dff) : LAM_W'(dff);
  assign rem2 = {rem, 1'b0};
  assign rem_ge = (rem2 >= {1'b0, den});
  assign slot = 4'(e) * 4'd3 + 4'(t);
  assign last_slot = (e == 2'd2) && (t == 2'd2);
  assign out_free = !out_valid || !out_stall;
  assign pop = (state == B_IDLE) && !q_empty;
  // load a held vertex into the output register this cycle
  assign out_load = held_valid && out_free &&
                    ((state == B_PUSH) || ((state == B_END) && ent.last));

  assign dx = {px[j][COORD_BITS-1], px[j]} - {px[e][COORD_BITS-1], px[e]};
  assign dy = {py[j][COORD_BITS-1], py[j]} - {py[e][COORD_BITS-1], py[e]};
  assign lam_s = P_W'($signed({1'b0, lam}));
  assign sum_x = P_W'(px[e]) + ((prod_x + P_W'(32768)) >>> 16);
  assign sum_y = P_W'(py[e]) + ((prod_y + P_W'(32768)) >>> 16);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
      held_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_load) out_valid <= 1'b1;
      else if (out_valid && !out_stall) out_valid <= 1'b0;
      case (state)
        B_IDLE: begin
          if (!q_empty) begin
            ent <= q_band;
            crd <= q_crd;
            e <= 2'd0;
            t <= 2'd0;
            k <= 4'd0;
            state <= q_band.emit ? B_SLOT : B_END;
          end
        end
        B_SLOT: begin
          if (!ent.mask[slot]) begin
            // advance past an empty slot
            if (last_slot) begin
              state <= B_END;
            end else if (t == 2'd2) begin
              e <= e + 2'd1;
              t <= 2'd0;
            end else begin
              t <= t + 2'd1;
            end
          end else if (t == 2'd2) begin
            cand_x <= px[j];
            cand_y <= py[j];
            state <= B_PUSH;
          end else if (an == ad) begin
            lam <= LAM_W'(1) << 16;
            state <= B_MUL;
          end else begin
            rem <= an;
            den <= ad;
            q <= '0;
            dcnt <= '0;
            state <= B_DIV;
          end
        end
        B_DIV: begin
          rem <= rem_ge ? LAM_W'(rem2 - {1'b0, den}) : LAM_W'(rem2);
          q <= {q[14:0], rem_ge};
          dcnt <= dcnt + 4'd1;
          if (dcnt == 4'd15) begin
            lam <= {1'b0, q[14:0], rem_ge};
            state <= B_MUL;
          end
        end
        B_MUL: begin
          prod_x <= P_W'(dx) * lam_s;
          prod_y <= P_W'(dy) * lam_s;
          state <= B_ADD;
        end
        B_ADD: begin
          cand_x <= sum_x[COORD_BITS-1:0];
          cand_y <= sum_y[COORD_BITS-1:0];
          state <= B_PUSH;
        end
        B_PUSH: begin
          if (!held_valid || out_free) begin
            if (held_valid) begin
              vertex_x <= held_x;
              vertex_y <= held_y;
              band_index <= held_band;
              vertex_index <= held_idx;
              polygon_end <= held_pend;
              triangle_end <= 1'b0;
            end
            held_valid <= 1'b1;
            held_x <= cand_x;
            held_y <= cand_y;
            held_band <= ent.band;
            held_idx <= k;
            held_pend <= (k == ent.count - 4'd1);
            k <= k + 4'd1;
            if (last_slot) begin
              state <= B_END;
            end else if (t == 2'd2) begin
              e <= e + 2'd1;
              t <= 2'd0;
              state <= B_SLOT;
            end else begin
              t <= t + 2'd1;
              state <= B_SLOT;
            end
          end
        end
        B_END: begin
          // flush the held vertex as the triangle's last result
          if (!ent.last || !held_valid) begin
            state <= B_IDLE;
          end else if (out_free) begin
            vertex_x <= held_x;
            vertex_y <= held_y;
            band_index <= held_band;
            vertex_index <= held_idx;
            polygon_end <= held_pend;
            triangle_end <= 1'b1;
            held_valid <= 1'b0;
            state <= B_IDLE;
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

endmodule

// ----- hdl/triangle_isoband_polygon_clip_unit.sv -----
// Top level of the triangle iso-band polygon clip unit: config registers,
// front classifier, band queue and back vertex generator; depends on tic_pkg.
//
//   channel  direction  handshake            payload
//   in       input      in_valid / in_stall  corner0..2 x, y, value
//   out      output     out_valid/out_stall  vertex_x/y, band_index, vertex_index, ends
//   cfg      input      cfg_we               cfg_index, cfg_data
//
// The front takes a triangle, then classifies its bands (level_count - 1, at most MAX_LEVELS - 1) in turn.
// The back walks the slots in turn, skipping empty ones; a corner vertex goes straight to the push, a
// crossing vertex passes the shared divider, then the multiply and add; the divider sets the pace.
// Synchronous active-high reset clears control state; no clearing pass.
// A stalled output holds the back; a full queue holds the front.
module triangle_isoband_polygon_clip_unit #(
  parameter int MAX_LEVELS = 8,
  parameter int COORD_BITS = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  logic signed [COORD_BITS-1:0] corner0_x,
  input  logic signed [COORD_BITS-1:0] corner0_y,
  input  logic signed [15:0] corner0_value,
  input  logic signed [COORD_BITS-1:0] corner1_x,
  input  logic signed [COORD_BITS-1:0] corner1_y,
  input  logic signed [15:0] corner1_value,
  input  logic signed [COORD_BITS-1:0] corner2_x,
  input  logic signed [COORD_BITS-1:0] corner2_y,
  input  logic signed [15:0] corner2_value,
  output logic out_valid,
  input  logic out_stall,
  output logic signed [COORD_BITS-1:0] vertex_x,
  output logic signed [COORD_BITS-1:0] vertex_y,
  output logic [2:0] band_index,
  output logic [3:0] vertex_index,
  output logic polygon_end,
  output logic triangle_end,
  input  logic cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [15:0] cfg_data
);
  import tic_pkg::*;

  localparam int Q_W = $bits(band_t) + 6*COORD_BITS;

  value_t level_base;
  logic [15:0] level_step;
  logic [3:0] level_count;
  logic [7:0] band_tolerance;

  logic push;
  logic pop;
  logic q_full;
  logic q_empty;
  band_t push_band;
  band_t q_band;
  logic [6*COORD_BITS-1:0] push_crd;
  logic [6*COORD_BITS-1:0] q_crd;
  logic [Q_W-1:0] q_rdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      level_base <= '0;
      level_step <= 16'd4096;
      level_count <= 4'd8;
      band_tolerance <= 8'd0;
    end else if (cfg_we) begin
      case (reg_index_t'(cfg_index))
        REG_LEVEL_BASE: level_base <= cfg_data;
        REG_LEVEL_STEP: level_step <= cfg_data;
        REG_LEVEL_COUNT: level_count <= cfg_data[3:0];
        REG_BAND_TOL: band_tolerance <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  tic_front #(.MAX_LEVELS(MAX_LEVELS), .COORD_BITS(COORD_BITS)) u_front (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .in_crd({corner2_y, corner2_x, corner1_y, corner1_x, corner0_y, corner0_x}),
    .in_f0(corner0_value), .in_f1(corner1_value), .in_f2(corner2_value),
    .level_base(level_base), .level_step(level_step), .level_count(level_count),
    .band_tolerance(band_tolerance), .q_full(q_full), .push(push),
    .push_band(push_band), .push_crd(push_crd)
  );

  tic_fifo #(.WIDTH(Q_W)) u_queue (
    .clk(clk), .rst(rst), .push(push), .wdata({push_band, push_crd}),
    .pop(pop), .rdata(q_rdata), .full(q_full), .empty(q_empty)
  );

  assign q_band = q_rdata[Q_W-1 -: $bits(band_t)];
  assign q_crd = q_rdata[6*COORD_BITS-1:0];

  tic_back #(.COORD_BITS(COORD_BITS)) u_back (
    .clk(clk), .rst(rst), .q_empty(q_empty), .pop(pop), .q_band(q_band),
    .q_crd(q_crd), .out_valid(out_valid), .out_stall(out_stall),
    .vertex_x(vertex_x), .vertex_y(vertex_y), .band_index(band_index),
    .vertex_index(vertex_index), .polygon_end(polygon_end),
    .triangle_end(triangle_end)
  );

  a_tri_end_closes_polygon: assert property (@(posedge clk) disable iff (rst)
    out_valid && triangle_end |-> polygon_end)
    else $error("triangle end without polygon end");

  a_vertex_index_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> vertex_index <= 4'd8)
    else $error("vertex index out of range");

  a_band_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> 32'(band_index) < MAX_LEVELS - 1)
    else $error("band index out of range");

  a_queue_no_overflow: assert property (@(posedge clk) disable iff (rst)
    q_full |=> !(q_full && push && !$past(pop)) || !$past(push))
    else $error("queue overflow");

endmodule

// ----- dv/tb_triangle_isoband_polygon_clip_unit.sv -----
// Self-checking bench for triangle_isoband_polygon_clip_unit: predicts band polygon
// vertices per triangle and compares every output transaction; depends on tic_pkg.
module tb_triangle_isoband_polygon_clip_unit;
  import tic_pkg::*;

  typedef struct {
    logic signed [15:0] x, y;
    logic [2:0] band;
    logic [3:0] vidx;
    logic pend, tend;
  } vertex_rec_t;

  typedef struct {
    logic signed [15:0] x[3], y[3], f[3];
  } tri_t;

  // Isoband polygon predictor plus queue of expected vertices
  class band_vertex_board;
    logic signed [15:0] base;
    logic [15:0] step;
    logic [3:0] lcount;
    logic [7:0] tol;
    vertex_rec_t pending[$];
    int errors;
    int polygons;
    int vertices;
    int last_idx;
    bit any;

    function void configure(reg_index_t idx, logic [15:0] d);
      case (idx)
        REG_LEVEL_BASE: base = d;
        REG_LEVEL_STEP: step = d;
        REG_LEVEL_COUNT: lcount = d[3:0];
        default: tol = d[7:0];
      endcase
    endfunction

    function longint lerp(longint pi, longint pj, longint lam);
      longint t;
      t = (pj - pi) * lam + 32768 + (longint'(1) << 32);
      return pi + t / 65536 - 65536;
    endfunction

    function void note_triangle(tri_t t);
      longint lv[8], px[9], py[9], lo, hi, fi, fj, ord[2], lvl, an, ad, lam, tl;
      int cnt, n, j;
      vertex_rec_t v;
      cnt = (lcount > 8) ? 8 : lcount;
      n = 0;
      tl = longint'(tol);
      if (cnt < 2) return;
      for (int k = 0; k < cnt; k++) lv[k] = longint'(base) + k * longint'(step);
      for (int b = 0; b + 1 < cnt; b++) begin
        lo = lv[b];
        hi = lv[b+1];
        n = 0;
        for (int e = 0; e < 3; e++) begin
          j = (e == 2) ? 0 : e + 1;
          fi = t.f[e];
          fj = t.f[j];
          ord[0] = (fj < fi) ? hi : lo;
          ord[1] = (fj < fi) ? lo : hi;
          for (int s = 0; s < 2; s++) begin
            lvl = ord[s];
            if (fi != fj && ((fi <= lvl && fj >= lvl) || (fi >= lvl && fj <= lvl))) begin
              an = (fi > lvl) ? fi - lvl : lvl - fi;
              ad = (fi > fj) ? fi - fj : fj - fi;
              lam = (an << 16) / ad;
              px[n] = lerp(t.x[e], t.x[j], lam);
              py[n] = lerp(t.y[e], t.y[j], lam);
              n++;
            end
          end
          if (lo - tl <= fj && fj <= hi + tl) begin
            px[n] = t.x[j];
            py[n] = t.y[j];
            n++;
          end
        end
        if (n > 2) begin
          polygons++;
          for (int k = 0; k < n; k++) begin
            v.x = px[k][15:0];
            v.y = py[k][15:0];
            v.band = 3'(b);
            v.vidx = 4'(k);
            v.pend = (k == n - 1);
            v.tend = 1'b0;
            pending.push_back(v);
          end
          last_idx = pending.size() - 1;
          any = 1;
        end
      end
    endfunction

    function void note_accepted(tri_t t);
      any = 0;
      note_triangle(t);
      if (any) pending[last_idx].tend = 1;
    endfunction

    function void check_vertex(vertex_rec_t a);
      vertex_rec_t e;
      vertices++;
      if (pending.size() == 0) begin
        $display("%0t: unexpected vertex x=%0d y=%0d band=%0d", $time, a.x, a.y, a.band);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (e.x !== a.x) begin
        $display("%0t: vertex_x expected %0d actual %0d", $time, e.x, a.x); errors++;
      end
      if (e.y !== a.y) begin
        $display("%0t: vertex_y expected %0d actual %0d", $time, e.y, a.y); errors++;
      end
      if (e.band !== a.band) begin
        $display("%0t: band_index expected %0d actual %0d", $time, e.band, a.band); errors++;
      end
      if (e.vidx !== a.vidx) begin
        $display("%0t: vertex_index expected %0d actual %0d", $time, e.vidx, a.vidx);
        errors++;
      end
      if (e.pend !== a.pend) begin
        $display("%0t: polygon_end expected %0d actual %0d", $time, e.pend, a.pend); errors++;
      end
      if (e.tend !== a.tend) begin
        $display("%0t: triangle_end expected %0d actual %0d", $time, e.tend, a.tend);
        errors++;
      end
    endfunction
  endclass

  logic clk = 0, rst = 1;
  logic in_valid = 0, in_stall, out_valid, out_stall = 0;
  logic signed [15:0] corner0_x = 0, corner0_y = 0, corner0_value = 0;
  logic signed [15:0] corner1_x = 0, corner1_y = 0, corner1_value = 0;
  logic signed [15:0] corner2_x = 0, corner2_y = 0, corner2_value = 0;
  logic signed [15:0] vertex_x, vertex_y;
  logic [2:0] band_index;
  logic [3:0] vertex_index;
  logic polygon_end, triangle_end;
  logic cfg_we = 0;
  logic [1:0] cfg_index = 0;
  logic [15:0] cfg_data = 0;

  band_vertex_board board;
  bit quiet_tail = 0;
  bit hold_long = 0;
  int idle_cycles = 0;
  int triangles = 0;

  always #5 clk = ~clk;

  triangle_isoband_polygon_clip_unit DUT (.*);

  // Sample both channels at the rising edge
  always @(posedge clk) begin
    vertex_rec_t r;
    if (!rst) begin
      if (in_valid && !in_stall) begin
        tri_t t;
        t.x[0] = corner0_x; t.y[0] = corner0_y; t.f[0] = corner0_value;
        t.x[1] = corner1_x; t.y[1] = corner1_y; t.f[1] = corner1_value;
        t.x[2] = corner2_x; t.y[2] = corner2_y; t.f[2] = corner2_value;
        board.note_accepted(t);
        triangles++;
      end
      if (out_valid && !out_stall) begin
        r.x = vertex_x; r.y = vertex_y; r.band = band_index; r.vidx = vertex_index;
        r.pend = polygon_end; r.tend = triangle_end;
        board.check_vertex(r);
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles > 20000) begin
        $display("FAILED: results differ");
        $finish;
      end
    end
  end

  // Receiver: random stall bursts, one long hold-off on request
  initial begin
    int n;
    forever begin
      @(negedge clk);
      if (hold_long) begin
        out_stall <= 1;
        repeat (600) @(negedge clk);
        out_stall <= 0;
        hold_long = 0;
      end else if (!quiet_tail && $urandom_range(0, 9) == 0) begin
        n = $urandom_range(1, 17);
        out_stall <= 1;
        repeat (n) @(negedge clk);
        out_stall <= 0;
      end
    end
  end

  task automatic write_reg(reg_index_t idx, logic [15:0] d);
    @(negedge clk);
    cfg_we <= 1; cfg_index <= idx; cfg_data <= d;
    board.configure(idx, d);
    @(negedge clk);
    cfg_we <= 0;
  endtask

  // Drop the input, then wait until every expected result has come
  task automatic drain();
    in_valid <= 0;
    while (board.pending.size() != 0) @(negedge clk);
    repeat (1200) @(negedge clk);
  endtask

  // Called at a falling edge; returns at the falling edge after acceptance
  task automatic send_triangle(tri_t t, bit gaps);
    if (gaps && !quiet_tail && $urandom_range(0, 7) == 0) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 17)) @(negedge clk);
    end
    corner0_x <= t.x[0]; corner0_y <= t.y[0]; corner0_value <= t.f[0];
    corner1_x <= t.x[1]; corner1_y <= t.y[1]; corner1_value <= t.f[1];
    corner2_x <= t.x[2]; corner2_y <= t.y[2]; corner2_value <= t.f[2];
    in_valid <= 1;
    while (in_stall) @(negedge clk);
    @(negedge clk);
  endtask

  function automatic tri_t rand_tri(int lo_v, int hi_v);
    tri_t t;
    for (int c = 0; c < 3; c++) begin
      t.x[c] = $urandom;
      t.y[c] = $urandom;
      t.f[c] = $urandom_range(hi_v - lo_v) + lo_v;
    end
    return t;
  endfunction

  function automatic tri_t make_tri(int f0, int f1, int f2, int ext);
    tri_t t;
    t.x[0] = ext ? -32768 : -100; t.y[0] = ext ? -32768 : 0;
    t.x[1] = ext ? 32767 : 100;   t.y[1] = ext ? -32768 : 0;
    t.x[2] = ext ? 0 : 0;         t.y[2] = ext ? 32767 : 173;
    t.f[0] = f0; t.f[1] = f1; t.f[2] = f2;
    return t;
  endfunction

  initial begin
    tri_t t;
    board = new();
    board.base = 0; board.step = 4096; board.lcount = 8; board.tol = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 0;

    // Directed: extremes, equal values, band corners, spanning edges
    send_triangle(make_tri(0, 28672, 14000, 1), 0);
    send_triangle(make_tri(-32768, 32767, 0, 1), 0);
    send_triangle(make_tri(5000, 5000, 5000, 0), 0);
    send_triangle(make_tri(4096, 4096, 12288, 0), 0);
    send_triangle(make_tri(32767, -32768, 32767, 1), 0);
    send_triangle(make_tri(-5, -3, -1, 0), 0);
    send_triangle(make_tri(0, 4096, 8192, 1), 0);
    send_triangle(make_tri(28672, 0, 100, 0), 0);
    drain();
    write_reg(REG_BAND_TOL, 255);
    write_reg(REG_LEVEL_BASE, 16'h8000);
    write_reg(REG_LEVEL_STEP, 65535);
    write_reg(REG_LEVEL_COUNT, 3);
    send_triangle(make_tri(-32768, 32767, 0, 1), 0);
    send_triangle(make_tri(-33000 + 300, 32767, 32767, 1), 0);
    drain();
    write_reg(REG_LEVEL_STEP, 1);
    write_reg(REG_LEVEL_COUNT, 15);
    write_reg(REG_LEVEL_BASE, 16'h7fff);
    send_triangle(make_tri(32767, 32760, -32768, 0), 0);
    drain();
    write_reg(REG_LEVEL_COUNT, 0);
    send_triangle(make_tri(0, 32767, -32768, 1), 0);
    drain();
    write_reg(REG_LEVEL_COUNT, 1);
    write_reg(REG_LEVEL_STEP, 0);
    send_triangle(make_tri(0, 32767, -32768, 1), 0);
    drain();
    write_reg(REG_LEVEL_COUNT, 4);
    write_reg(REG_LEVEL_BASE, 0);
    send_triangle(make_tri(0, 32767, -32768, 1), 0);
    send_triangle(make_tri(0, 0, 10, 0), 0);
    drain();

    // Random phases over several register settings
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin write_reg(REG_LEVEL_BASE, 0); write_reg(REG_LEVEL_STEP, 4096);
                 write_reg(REG_LEVEL_COUNT, 8); write_reg(REG_BAND_TOL, 0); end
        1: begin write_reg(REG_LEVEL_BASE, -16000); write_reg(REG_LEVEL_STEP, 6000);
                 write_reg(REG_LEVEL_COUNT, 7); write_reg(REG_BAND_TOL, 40); end
        2: begin write_reg(REG_LEVEL_BASE, $urandom); write_reg(REG_LEVEL_STEP, $urandom);
                 write_reg(REG_LEVEL_COUNT, $urandom_range(0, 15));
                 write_reg(REG_BAND_TOL, $urandom); end
        3: begin write_reg(REG_LEVEL_BASE, -32768); write_reg(REG_LEVEL_STEP, 9362);
                 write_reg(REG_LEVEL_COUNT, 8); write_reg(REG_BAND_TOL, 255); end
        4: begin write_reg(REG_LEVEL_BASE, -300); write_reg(REG_LEVEL_STEP, 100);
                 write_reg(REG_LEVEL_COUNT, 5); write_reg(REG_BAND_TOL, 7); end
        default: begin write_reg(REG_LEVEL_BASE, -32768); write_reg(REG_LEVEL_STEP, 9362);
                 write_reg(REG_LEVEL_COUNT, 8); write_reg(REG_BAND_TOL, 0); end
      endcase
      if (ph == 1) hold_long = 1;
      if (ph == 5) quiet_tail = 1;
      for (int i = 0; i < 56; i++) begin
        if (ph == 4) t = rand_tri(-500, 500);
        else if (ph == 3 || $urandom_range(0, 3) == 0) t = rand_tri(-32768, 32767);
        else t = rand_tri(-1000, 29000);
        if ($urandom_range(0, 9) == 0) t.f[1] = t.f[0];
        send_triangle(t, 1);
        if (ph == 2 && i == 20) drain();
      end
      drain();
    end

    $display("Covered %0d triangles, %0d band polygons, %0d vertices checked",
             triangles, board.polygons, board.vertices);
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end
endmodule
